### design/pdz_pkg.sv
// Shared types and constants of the periodic delta zigzag encoder.
`timescale 1ns / 1ps
package pdz_pkg;

  localparam int POS_W        = 16;
  localparam int AXIS_W       = 2;
  localparam int BYTE_W       = 8;
  localparam int COUNT_W      = 20;
  localparam int DIFF_W       = POS_W + 2;
  localparam int MAX_COORDS   = 262144;
  localparam int COUNT_LIMIT  = (1 << COUNT_W) - 1;
  localparam int COUNT_CAP_INT =
      (3 * MAX_COORDS < COUNT_LIMIT) ? 3 * MAX_COORDS : COUNT_LIMIT;
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_INT);
  localparam logic [POS_W-1:0]   MAG_MAX   = 16'h8000;
  localparam logic [BYTE_W-1:0]  ESC_CODE  = 8'hFF;
  localparam logic [POS_W-1:0]   BOUND_RST = 16'hFFFF;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [AXIS_W-1:0] {
    CFG_BOUND_X = 2'd0,
    CFG_BOUND_Y = 2'd1,
    CFG_BOUND_Z = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEL_FIRST,
    SEL_LOW,
    SEL_HIGH
  } byte_sel_e;

  typedef struct packed {
    logic [POS_W-1:0]   zz;
    logic               esc;
    logic [BYTE_W-1:0]  delta_byte;
    logic [POS_W-1:0]   max_abs;
    logic [COUNT_W-1:0] count;
  } pdz_entry_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } pdz_head_ctl_t;

endpackage

### design/pdz_front.sv
// Front end: bound registers, delta wrap, zigzag classification and frame totals.
`timescale 1ns / 1ps
module pdz_front
  import pdz_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [AXIS_W-1:0]  cfg_index_i,
  input  logic [POS_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [POS_W-1:0]   prev_position_i,
  input  logic [POS_W-1:0]   target_position_i,
  input  logic [AXIS_W-1:0]  axis_i,
  input  logic               frame_start_i,
  input  logic               full_i,
  output logic               push_o,
  output pdz_entry_t         entry_o
);

  logic [POS_W-1:0] bound_x_q, bound_y_q, bound_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_x_q <= BOUND_RST;
      bound_y_q <= BOUND_RST;
      bound_z_q <= BOUND_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_BOUND_X: bound_x_q <= cfg_data_i;
        CFG_BOUND_Y: bound_y_q <= cfg_data_i;
        CFG_BOUND_Z: bound_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_q, s2_valid_q;
  logic in_acc, adv2, push;

  assign push       = s2_valid_q & ~full_i;
  assign adv2       = ~s2_valid_q | push;
  assign in_stall_o = s1_valid_q & ~adv2;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign push_o     = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv2) begin
        s1_valid_q <= 1'b0;
      end
      if (adv2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // stage 1: raw difference and bound select
  logic signed [DIFF_W-1:0] diff_d, diff_q;
  logic [POS_W-1:0]         bound_d, bound_q;
  logic                     fs1_q;

  assign diff_d = $signed({2'b00, target_position_i}) - $signed({2'b00, prev_position_i});

  always_comb begin
    case (axis_i)
      CFG_BOUND_X: bound_d = bound_x_q;
      CFG_BOUND_Y: bound_d = bound_y_q;
      default:     bound_d = bound_z_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      diff_q  <= diff_d;
      bound_q <= bound_d;
      fs1_q   <= frame_start_i;
    end
  end

  // stage 2: periodic wrap, both corrections evaluated in parallel
  logic signed [DIFF_W-1:0] bnd_s, half_s, nhalf_s, d_minus, d_plus, d_wrap;
  logic                     over, under_m, under_p;
  logic [POS_W-1:0]         d16_q;
  logic                     fs2_q;

  always_comb begin
    bnd_s   = $signed({2'b00, bound_q});
    half_s  = $signed({3'b000, bound_q[POS_W-1:1]});
    nhalf_s = -half_s;
    d_minus = diff_q - bnd_s;
    d_plus  = diff_q + bnd_s;
    over    = diff_q > half_s;
    under_m = d_minus < nhalf_s;
    under_p = diff_q < nhalf_s;
    if (over) begin
      d_wrap = under_m ? diff_q : d_minus;
    end else begin
      d_wrap = under_p ? d_plus : diff_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_valid_q) begin
      d16_q <= d_wrap[POS_W-1:0];
      fs2_q <= fs1_q;
    end
  end

  // classification and frame totals, committed on push
  logic [POS_W-1:0]   max_q, max_d, max_base, mag;
  logic [COUNT_W-1:0] cnt_q, cnt_d, cnt_base;
  logic [COUNT_W:0]   cnt_sum;
  logic [POS_W-1:0]   zz;
  logic               neg, esc;
  logic [1:0]         nbytes;

  always_comb begin
    neg      = d16_q[POS_W-1];
    mag      = neg ? (POS_W'(0) - d16_q) : d16_q;
    max_base = fs2_q ? '0 : max_q;
    cnt_base = fs2_q ? '0 : cnt_q;
    max_d    = (mag > max_base) ? mag : max_base;
    zz       = {d16_q[POS_W-2:0], 1'b0} ^ {POS_W{neg}};
    esc      = zz >= {8'h00, ESC_CODE};
    nbytes   = esc ? 2'd3 : 2'd1;
    cnt_sum  = {1'b0, cnt_base} + (COUNT_W + 1)'(nbytes);
    cnt_d    = (cnt_sum > {1'b0, COUNT_CAP}) ? COUNT_CAP : cnt_sum[COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      cnt_q <= '0;
    end else if (push) begin
      max_q <= max_d;
      cnt_q <= cnt_d;
    end
  end

  assign entry_o = '{zz: zz, esc: esc, delta_byte: d16_q[BYTE_W-1:0],
                     max_abs: max_d, count: cnt_d};

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= COUNT_CAP)
    else $error("frame byte count above cap");
  a_max_range: assert property (@(posedge clk_i) disable iff (!rst_ni) max_q <= MAG_MAX)
    else $error("running max above half range");

endmodule

### design/pdz_fifo.sv
// Small queue of classified coordinates between front and back end.
`timescale 1ns / 1ps
module pdz_fifo
  import pdz_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pdz_entry_t    entry_i,
  output logic          full_o,
  input  pdz_head_ctl_t head_i,
  output logic          valid_o,
  output pdz_entry_t    head_o
);

  pdz_entry_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]    count_q;
  logic                pop;

  assign full_o  = count_q == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = head_i.pop & head_i.valid & valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
                                  !(push_i && full_o))
    else $error("push into full queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
                                  count_q <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

### design/pdz_back.sv
// Back end: expands each queued coordinate into one or three code bytes.
`timescale 1ns / 1ps
module pdz_back
  import pdz_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  pdz_entry_t         head_i,
  output pdz_head_ctl_t      head_ctl_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BYTE_W-1:0]  code_byte_o,
  output logic               last_of_run_o,
  output logic [BYTE_W-1:0]  delta_byte_o,
  output logic [POS_W-1:0]   max_abs_so_far_o,
  output logic [COUNT_W-1:0] coded_bytes_so_far_o
);

  byte_sel_e          sel_q, sel_d;
  logic               out_valid_q;
  logic [BYTE_W-1:0]  code_q, delta_q, code_d;
  logic               last_q, last_d;
  logic [POS_W-1:0]   max_q;
  logic [COUNT_W-1:0] cnt_q;
  logic               load, fire;

  assign load = ~out_valid_q | ~out_stall_i;
  assign fire = load & head_valid_i;

  always_comb begin
    sel_d = sel_q;
    if (fire) begin
      unique case (sel_q)
        SEL_FIRST: sel_d = head_i.esc ? SEL_LOW : SEL_FIRST;
        SEL_LOW:   sel_d = SEL_HIGH;
        SEL_HIGH:  sel_d = SEL_FIRST;
        default:   sel_d = SEL_FIRST;
      endcase
    end
  end

  always_comb begin
    unique case (sel_q)
      SEL_FIRST: begin
        code_d = head_i.esc ? ESC_CODE : head_i.zz[BYTE_W-1:0];
        last_d = ~head_i.esc;
      end
      SEL_LOW: begin
        code_d = head_i.zz[BYTE_W-1:0];
        last_d = 1'b0;
      end
      SEL_HIGH: begin
        code_d = head_i.zz[POS_W-1:BYTE_W];
        last_d = 1'b1;
      end
      default: begin
        code_d = head_i.zz[BYTE_W-1:0];
        last_d = 1'b1;
      end
    endcase
  end

  assign head_ctl_o = '{valid: head_valid_i, pop: fire & last_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= SEL_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
      if (load) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      code_q  <= code_d;
      last_q  <= last_d;
      delta_q <= head_i.delta_byte;
      max_q   <= head_i.max_abs;
      cnt_q   <= head_i.count;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign code_byte_o          = code_q;
  assign last_of_run_o        = last_q;
  assign delta_byte_o         = delta_q;
  assign max_abs_so_far_o     = max_q;
  assign coded_bytes_so_far_o = cnt_q;

  a_mid_run_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
                                   (sel_q != SEL_FIRST) |-> head_valid_i)
    else $error("escape run lost its queue entry");

endmodule

### design/periodic_delta_zigzag_encoder.sv
// Top level of the periodic delta zigzag escape-byte encoder.
//
// Input channel: one coordinate word per accepted cycle (in_valid_i high,
// in_stall_o low): previous and target position, axis and frame start.
// Output channel: one code byte word per accepted cycle (out_valid_o high,
// out_stall_i low). A coordinate whose zigzag code is below 255 yields one
// word; otherwise three (escape, low byte, high byte), last_of_run_o on the
// final one. Each word also carries the delta low byte and the frame totals.
// A coordinate passes front stages 1 and 2, the queue and the back end
// output register. Throughput: one output word per cycle while out_stall_i
// is low, so one coordinate per cycle for short codes, and escaped codes take
// three words; the byte expander in the back end sets that rate. A 4-entry
// queue separates front and back, so input keeps flowing while the output
// is stalled until the queue and the two front stages fill, then in_stall_o
// rises. Configuration: cfg_ready_o is always high; indices 0..2 write the
// x, y and z bounds, index 3 is ignored. Write only while the block is idle.
// Reset clears the pipeline, queue and frame totals; bounds reset to 65535.
`timescale 1ns / 1ps
module periodic_delta_zigzag_encoder
  import pdz_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [AXIS_W-1:0]  cfg_index_i,
  input  logic [POS_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [POS_W-1:0]   prev_position_i,
  input  logic [POS_W-1:0]   target_position_i,
  input  logic [AXIS_W-1:0]  axis_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BYTE_W-1:0]  code_byte_o,
  output logic               last_of_run_o,
  output logic [BYTE_W-1:0]  delta_byte_o,
  output logic [POS_W-1:0]   max_abs_so_far_o,
  output logic [COUNT_W-1:0] coded_bytes_so_far_o
);

  logic          push, full, head_valid;
  pdz_entry_t    entry, head;
  pdz_head_ctl_t head_ctl;

  assign cfg_ready_o = 1'b1;

  pdz_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .prev_position_i   (prev_position_i),
    .target_position_i (target_position_i),
    .axis_i            (axis_i),
    .frame_start_i     (frame_start_i),
    .full_i            (full),
    .push_o            (push),
    .entry_o           (entry)
  );

  pdz_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .head_i  (head_ctl),
    .valid_o (head_valid),
    .head_o  (head)
  );

  pdz_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .head_valid_i         (head_valid),
    .head_i               (head),
    .head_ctl_o           (head_ctl),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .code_byte_o          (code_byte_o),
    .last_of_run_o        (last_of_run_o),
    .delta_byte_o         (delta_byte_o),
    .max_abs_so_far_o     (max_abs_so_far_o),
    .coded_bytes_so_far_o (coded_bytes_so_far_o)
  );

endmodule

### tb/tb_periodic_delta_zigzag_encoder.sv
// Testbench for the periodic delta zigzag encoder: predicted code words checked in order.
`timescale 1ns / 1ps
module tb_periodic_delta_zigzag_encoder;
  import pdz_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int SEGMENTS       = 6;
  localparam int SEGMENT_ITEMS  = 38;
  localparam logic [AXIS_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [AXIS_W-1:0] {
    AX_X   = 2'd0,
    AX_Y   = 2'd1,
    AX_Z   = 2'd2,
    AX_ALT = 2'd3
  } axis_e;

  typedef struct packed {
    logic [POS_W-1:0] prev;
    logic [POS_W-1:0] target;
    axis_e            axis;
    logic             fstart;
  } coord_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  code;
    logic               last;
    logic [BYTE_W-1:0]  delta;
    logic [POS_W-1:0]   max_abs;
    logic [COUNT_W-1:0] count;
  } code_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [AXIS_W-1:0]  cfg_index_i = '0;
  logic [POS_W-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [POS_W-1:0]   prev_position_i = '0;
  logic [POS_W-1:0]   target_position_i = '0;
  logic [AXIS_W-1:0]  axis_i = '0;
  logic               frame_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [BYTE_W-1:0]  code_byte_o;
  logic               last_of_run_o;
  logic [BYTE_W-1:0]  delta_byte_o;
  logic [POS_W-1:0]   max_abs_so_far_o;
  logic [COUNT_W-1:0] coded_bytes_so_far_o;

  periodic_delta_zigzag_encoder dut (.*);

  coord_t     coord_q[$];
  code_word_t code_q[$];
  coord_t     cur_coord;
  code_word_t want_w;

  logic [POS_W-1:0]   bnd_x = BOUND_RST;
  logic [POS_W-1:0]   bnd_y = BOUND_RST;
  logic [POS_W-1:0]   bnd_z = BOUND_RST;
  logic [POS_W-1:0]   frame_max_abs = '0;
  logic [COUNT_W-1:0] frame_byte_count = '0;

  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  quiet_cycles = 0;
  logic in_taken = 1'b0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;
  wire cfg_fire = cfg_valid_i && cfg_ready_o;

  initial forever #5 clk_i = ~clk_i;

  function automatic logic [POS_W-1:0] axis_bound(axis_e ax);
    case (ax)
      AX_X:    return bnd_x;
      AX_Y:    return bnd_y;
      default: return bnd_z;
    endcase
  endfunction

  function automatic void put_word(code_word_t w);
    code_q = {code_q, w};
  endfunction

  function automatic void encode_coord(logic [POS_W-1:0] prev, logic [POS_W-1:0] target,
                                       axis_e ax, logic fstart);
    int               d, half, b, cnt;
    logic [POS_W-1:0] d16, mag, zz;
    logic             neg;
    if (fstart) begin
      frame_max_abs    = '0;
      frame_byte_count = '0;
    end
    b    = int'(axis_bound(ax));
    half = b / 2;
    d    = int'(target) - int'(prev);
    if (d > half) d -= b;
    if (d < -half) d += b;
    d16 = d[POS_W-1:0];
    neg = d16[POS_W-1];
    mag = neg ? POS_W'(17'h10000 - {1'b0, d16}) : d16;
    if (mag > frame_max_abs) frame_max_abs = mag;
    zz  = {d16[POS_W-2:0], 1'b0} ^ {POS_W{neg}};
    cnt = int'(frame_byte_count) + ((zz < POS_W'(ESC_CODE)) ? 1 : 3);
    if (cnt > COUNT_CAP_INT) cnt = COUNT_CAP_INT;
    frame_byte_count = cnt[COUNT_W-1:0];
    if (zz < POS_W'(ESC_CODE)) begin
      put_word('{zz[7:0], 1'b1, d16[7:0], frame_max_abs, frame_byte_count});
    end else begin
      put_word('{ESC_CODE, 1'b0, d16[7:0], frame_max_abs, frame_byte_count});
      put_word('{zz[7:0], 1'b0, d16[7:0], frame_max_abs, frame_byte_count});
      put_word('{zz[15:8], 1'b1, d16[7:0], frame_max_abs, frame_byte_count});
    end
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      n_errors++;
    end
  endfunction

  function automatic void add_coord(logic [POS_W-1:0] prev, logic [POS_W-1:0] target,
                                    axis_e ax, logic fstart);
    coord_t c;
    c       = '{prev, target, ax, fstart};
    coord_q = {coord_q, c};
    n_queued++;
  endfunction

  function automatic logic [POS_W-1:0] pick_bound();
    case ($urandom_range(5))
      0:       return 16'hFFFF;
      1:       return 16'd1;
      2:       return 16'd0;
      3:       return POS_W'($urandom_range(2, 400));
      default: return POS_W'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic void add_random_coord();
    logic [POS_W-1:0] p, t;
    axis_e            ax;
    int               b;
    p  = POS_W'($urandom);
    t  = POS_W'($urandom);
    ax = axis_e'($urandom_range(3));
    b  = int'(axis_bound(ax));
    case ($urandom_range(3))
      0: t = p + POS_W'($urandom_range(254)) - 16'd127;
      1: begin
        if (b > 0) begin
          p = POS_W'($urandom_range(b - 1));
          t = POS_W'($urandom_range(b - 1));
        end
      end
      2: t = p + POS_W'($urandom_range(4000)) - 16'd2000;
      default: ;
    endcase
    add_coord(p, t, ax, $urandom_range(9) == 0);
  endfunction

  task automatic write_reg(logic [AXIS_W-1:0] idx, logic [POS_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_BOUND_X: bnd_x = val;
      CFG_BOUND_Y: bnd_y = val;
      CFG_BOUND_Z: bnd_z = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_queued != n_accepted || code_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // driver
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    if (!in_valid_i || in_taken) begin
      if (coord_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_coord = coord_q.pop_front();
        in_valid_i        <= 1'b1;
        prev_position_i   <= cur_coord.prev;
        target_position_i <= cur_coord.target;
        axis_i            <= cur_coord.axis;
        frame_start_i     <= cur_coord.fstart;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    in_taken <= in_fire;
    if (rst_ni && out_fire) begin
      if (code_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual code %0h", $time, code_byte_o);
        n_errors++;
      end else begin
        want_w = code_q.pop_front();
        check_field("code_byte", want_w.code, code_byte_o);
        check_field("last_of_run", want_w.last, last_of_run_o);
        check_field("delta_byte", want_w.delta, delta_byte_o);
        check_field("max_abs_so_far", want_w.max_abs, max_abs_so_far_o);
        check_field("coded_bytes_so_far", want_w.count, coded_bytes_so_far_o);
      end
    end
    if (rst_ni && in_fire) begin
      encode_coord(prev_position_i, target_position_i, axis_e'(axis_i), frame_start_i);
      n_accepted++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire || cfg_fire) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset bounds: escape boundary, wrap at full range, frame starts, every axis
    send_idle_pct = 35;
    recv_idle_pct = 61;
    add_coord(16'd0, 16'd0, AX_X, 1'b1);
    add_coord(16'd0, 16'd1, AX_X, 1'b0);
    add_coord(16'd1, 16'd0, AX_X, 1'b0);
    add_coord(16'd0, 16'd127, AX_Y, 1'b0);
    add_coord(16'd0, 16'd128, AX_Y, 1'b0);
    add_coord(16'd128, 16'd0, AX_Z, 1'b0);
    add_coord(16'd0, 16'hFFFF, AX_Z, 1'b1);
    add_coord(16'hFFFF, 16'd0, AX_X, 1'b0);
    add_coord(16'd0, 16'h7FFF, AX_X, 1'b0);
    add_coord(16'h7FFF, 16'd0, AX_Y, 1'b0);
    add_coord(16'd0, 16'h8000, AX_Y, 1'b0);
    add_coord(16'hFFFF, 16'hFFFF, AX_ALT, 1'b0);
    add_coord(16'd0, 16'd10, AX_ALT, 1'b1);
    wait_drained();

    // zero bound, unit bound, positions beyond a small bound, axis three
    write_reg(CFG_BOUND_X, 16'd0);
    write_reg(CFG_BOUND_Y, 16'd1);
    write_reg(CFG_BOUND_Z, 16'd100);
    write_reg(CFG_UNUSED, 16'd7);
    repeat (2) @(posedge clk_i);
    add_coord(16'h8000, 16'd0, AX_X, 1'b1);
    add_coord(16'd0, 16'h8000, AX_X, 1'b0);
    add_coord(16'd0, 16'hFFFF, AX_X, 1'b0);
    add_coord(16'hFFFF, 16'd0, AX_X, 1'b0);
    add_coord(16'd5, 16'd9, AX_Y, 1'b0);
    add_coord(16'd0, 16'd200, AX_Z, 1'b0);
    add_coord(16'hFFFF, 16'd0, AX_Z, 1'b0);
    add_coord(16'd0, 16'd60, AX_ALT, 1'b0);
    add_coord(16'd99, 16'd0, AX_ALT, 1'b1);
    wait_drained();

    for (int s = 0; s < SEGMENTS; s++) begin
      case (s / 2)
        0: begin send_idle_pct = 35; recv_idle_pct = 61; end
        1: begin send_idle_pct = 61; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(CFG_BOUND_X, (s == 0) ? 16'hFFFF : pick_bound());
      write_reg(CFG_BOUND_Y, (s == 0) ? 16'd1 : pick_bound());
      write_reg(CFG_BOUND_Z, pick_bound());
      if (s == 1) write_reg(CFG_UNUSED, POS_W'($urandom));
      repeat (2) @(posedge clk_i);
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
        if (i == SEGMENT_ITEMS / 2) wait_drained();
        add_random_coord();
      end
      wait_drained();
    end

    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### periodic_delta_zigzag_encoder.f
design/pdz_pkg.sv
design/pdz_front.sv
design/pdz_fifo.sv
design/pdz_back.sv
design/periodic_delta_zigzag_encoder.sv
tb/tb_periodic_delta_zigzag_encoder.sv
